// ===== sv/hashed_block_cache_lru_refcount_assert.svh =====
// Assertion macros used by the checker of the block cache tag engine.
`ifndef HASHED_BLOCK_CACHE_LRU_REFCOUNT_ASSERT_SVH
`define HASHED_BLOCK_CACHE_LRU_REFCOUNT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hbc_pkg.sv =====
// Types and constants shared by the block cache tag engine.
package hbc_pkg;

  localparam int BLK_W       = 32;
  localparam int DEV_W       = 8;
  localparam int CNT_W       = 8;
  localparam int STAMP_W     = 32;
  localparam int HANDLE_W    = 3;
  localparam int WAY_OUT_W   = 3;
  localparam int SET_OUT_W   = 4;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = 5;

  // Set index reduction: four block-number bits per cycle.
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = BLK_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX  = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_ZERO = 8'h00;
  localparam logic [CNT_W-1:0] CNT_ONE  = 8'h01;

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_RELEASE = 2'd1,
    FN_PIN     = 2'd2,
    FN_UNPIN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_NOWAY = 2'd1,
    STS_COUNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_GWR,
    ST_RD,
    ST_RMW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               vld;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
    logic [BLK_W-1:0]   blk;
    logic [DEV_W-1:0]   dev;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic match;
    logic better;
  } cmp_res_t;

endpackage

// ===== sv/hbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/hbc_setmod.sv =====
// Iterative block-number reduction modulo the set count, four bits per cycle.
module hbc_setmod #(
  parameter int NUM_SETS = 13,
  parameter int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hbc_pkg::BLK_W-1:0] blk,
  output logic                     done,
  output logic [SET_W-1:0]         set_idx
);

  import hbc_pkg::*;

  localparam int RW = $clog2(NUM_SETS + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [BLK_W-1:0]     sh_r;
  logic [RW-1:0]        rem_r;
  logic [RW-1:0]        rem_nxt;

  // Shift in one bit at a time; the remainder stays below NUM_SETS, so a
  // single conditional subtract keeps it reduced.
  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {r, sh_r[BLK_W-1-i]};
      if (t >= (RW+1)'(NUM_SETS)) begin
        t = t - (RW+1)'(NUM_SETS);
      end
      r = t[RW-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sh_r   <= blk;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_r << MOD_BITS;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign set_idx = rem_r[SET_W-1:0];

endmodule

// ===== sv/hbc_cmp.sv =====
// Shared way compare unit: tag match and LRU victim preference for one way.
module hbc_cmp (
  input  hbc_pkg::entry_t              entry,
  input  logic [hbc_pkg::DEV_W-1:0]    dev,
  input  logic [hbc_pkg::BLK_W-1:0]    blk,
  input  logic                         have,
  input  logic [hbc_pkg::STAMP_W-1:0]  best,
  output hbc_pkg::cmp_res_t            res
);

  import hbc_pkg::*;

  // Tags are compared whether or not the way is valid.
  always_comb begin
    res.match  = (entry.dev == dev) && (entry.blk == blk);
    res.better = (entry.cnt == CNT_ZERO) && (!have || (entry.stamp < best));
  end

endmodule

// ===== sv/hashed_block_cache_lru_refcount.sv =====
// Top level of the block cache tag and replacement engine.
//
// This block keeps the tags, reference counts and last-use stamps of a
// set-associative block cache (NUM_SETS sets of NUM_WAYS ways) and answers
// one request at a time. A get reduces the block number modulo NUM_SETS
// with an iterative divider that takes four bits per cycle,
// then reads the ways of that set one per cycle through the single read
// port of the tag RAM, where one shared compare unit checks the tags and
// tracks the unreferenced way with the smallest stamp (lowest way on ties).
// A hit bumps the count (saturating at 255) and restamps the way; a miss
// retags the chosen way with count one and reports that a fill is needed;
// a set whose ways are all referenced reports status 1 and is left alone.
// Release, pin and unpin read, adjust and write back the addressed way's
// count, with status 2 for saturation, underflow or a way handle past the
// set. A get runs the divider, the way scan, the tag write and the output
// state; release, pin and unpin run the divider, a read, a read-modify-write
// and the output state, with no read or write when the handle is past the
// set. A result waits in the output state until the one before is taken
// on out_tready. The result sits in an output register, so the block returns
// to accepting requests once the previous result is held there. All state
// reads as zero after reset: each RAM entry has a flip-flop that marks it
// written since reset, and an unwritten entry reads as all zero, so no
// clearing pass is needed.
module hashed_block_cache_lru_refcount #(
  parameter int NUM_SETS = 13,
  parameter int NUM_WAYS = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // device_id[7:0], block_number[39:8], way_handle[42:40], now_tick[74:43], zeros
  input  logic [hbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // way_out[2:0], set_out[6:3], hit[7], needs_fill[8], status[10:9], zeros
  output logic [hbc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import hbc_pkg::*;

  localparam int NUM_ENTRIES = NUM_SETS * NUM_WAYS;
  localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SET_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W       = $clog2(NUM_WAYS + 1);

  state_t state_r, state_nxt;

  // Request registers.
  func_t                func_r;
  logic [DEV_W-1:0]     dev_r;
  logic [BLK_W-1:0]     blk_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [STAMP_W-1:0]   now_r;
  logic                 handle_bad;

  // Set index unit.
  logic                 mod_start;
  logic                 mod_done;
  logic [SET_W-1:0]     set_idx;

  // Tag RAM and the written-since-reset marks.
  logic [NUM_ENTRIES-1:0] init_r;
  logic                 init_q_r;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_addr;
  logic [ENTRY_W-1:0]   ram_q;
  entry_t               entry_rd;
  entry_t               wr_ent;

  // Way scan.
  logic [WAY_W-1:0]     way_sel;
  logic [WAY_W-1:0]     rd_idx_r;
  logic [WAY_W-1:0]     ev_idx_r;
  logic                 ev_vld_r;
  logic                 found_r;
  logic [WAY_W-1:0]     hit_way_r;
  logic [CNT_W-1:0]     hit_cnt_r;
  logic                 hit_vld_r;
  logic                 have_r;
  logic [STAMP_W-1:0]   best_r;
  logic [WAY_W-1:0]     vic_way_r;
  cmp_res_t             cmp_res;

  // Result.
  status_t              upd_sts;
  logic [WAY_OUT_W-1:0] res_way_r;
  logic                 res_hit_r;
  logic                 res_fill_r;
  status_t              res_sts_r;
  logic                 out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                 out_load;

  assign handle_bad = 32'(handle_r) >= 32'(NUM_WAYS);
  assign entry_rd   = init_q_r ? entry_t'(ram_q) : '0;
  assign out_load   = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  hbc_setmod #(
    .NUM_SETS (NUM_SETS),
    .SET_W    (SET_W)
  ) u_setmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .blk     (in_tdata[DEV_W +: BLK_W]),
    .done    (mod_done),
    .set_idx (set_idx)
  );

  hbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENTRIES),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_q)
  );

  hbc_cmp u_cmp (
    .entry (entry_rd),
    .dev   (dev_r),
    .blk   (blk_r),
    .have  (have_r),
    .best  (best_r),
    .res   (cmp_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          if (func_r == FN_GET) begin
            state_nxt = ST_SCAN;
          end else if (handle_bad) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_SCAN: begin
        if ((rd_idx_r == WAY_W'(NUM_WAYS)) && !ev_vld_r) begin
          state_nxt = ST_GWR;
        end
      end
      ST_GWR:  state_nxt = ST_OUT;
      ST_RD:   state_nxt = ST_RMW;
      ST_RMW:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: handshake, RAM port and the entry to write back.
  always_comb begin
    in_tready = 1'b0;
    mod_start = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    way_sel   = '0;
    upd_sts   = STS_OK;
    wr_ent    = entry_rd;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mod_start = in_tvalid;
      end
      ST_SCAN: begin
        ram_re  = rd_idx_r < WAY_W'(NUM_WAYS);
        way_sel = rd_idx_r;
      end
      ST_GWR: begin
        way_sel      = found_r ? hit_way_r : vic_way_r;
        wr_ent.vld   = 1'b1;
        wr_ent.dev   = dev_r;
        wr_ent.blk   = blk_r;
        wr_ent.stamp = now_r;
        wr_ent.cnt   = CNT_ONE;
        if (found_r) begin
          ram_we = 1'b1;
          if (hit_cnt_r == CNT_MAX) begin
            wr_ent.cnt = CNT_MAX;
            upd_sts    = STS_COUNT;
          end else begin
            wr_ent.cnt = hit_cnt_r + 1'b1;
          end
        end else if (have_r) begin
          ram_we = 1'b1;
        end else begin
          upd_sts = STS_NOWAY;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        way_sel = WAY_W'(handle_r);
      end
      ST_RMW: begin
        ram_we  = 1'b1;
        way_sel = WAY_W'(handle_r);
        if (func_r == FN_PIN) begin
          if (entry_rd.cnt == CNT_MAX) begin
            upd_sts = STS_COUNT;
          end else begin
            wr_ent.cnt = entry_rd.cnt + 1'b1;
          end
        end else begin
          if (entry_rd.cnt == CNT_ZERO) begin
            upd_sts = STS_COUNT;
          end else begin
            wr_ent.cnt = entry_rd.cnt - 1'b1;
          end
        end
      end
      default: ;
    endcase
    ram_addr = ADDR_W'(32'(set_idx) * 32'(NUM_WAYS) + 32'(way_sel));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      init_r       <= '0;
      rd_idx_r     <= '0;
      ev_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      have_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        init_r[ram_addr] <= 1'b1;
      end
      if (mod_start) begin
        rd_idx_r <= '0;
        ev_vld_r <= 1'b0;
        found_r  <= 1'b0;
        have_r   <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        ev_vld_r <= ram_re;
        if (ram_re) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        if (ev_vld_r) begin
          if (!found_r && cmp_res.match) begin
            found_r <= 1'b1;
          end
          if (cmp_res.better) begin
            have_r <= 1'b1;
          end
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mod_start) begin
      func_r     <= func_t'(in_tuser);
      dev_r      <= in_tdata[0 +: DEV_W];
      blk_r      <= in_tdata[DEV_W +: BLK_W];
      handle_r   <= in_tdata[DEV_W + BLK_W +: HANDLE_W];
      now_r      <= in_tdata[DEV_W + BLK_W + HANDLE_W +: STAMP_W];
      res_way_r  <= WAY_OUT_W'(in_tdata[DEV_W + BLK_W +: HANDLE_W]);
      res_hit_r  <= 1'b0;
      res_fill_r <= 1'b0;
      res_sts_r  <= STS_OK;
    end
    if (ram_re) begin
      init_q_r <= init_r[ram_addr];
    end
    if (state_r == ST_SCAN) begin
      ev_idx_r <= rd_idx_r;
      if (ev_vld_r) begin
        if (!found_r && cmp_res.match) begin
          hit_way_r <= ev_idx_r;
          hit_cnt_r <= entry_rd.cnt;
          hit_vld_r <= entry_rd.vld;
        end
        if (cmp_res.better) begin
          best_r    <= entry_rd.stamp;
          vic_way_r <= ev_idx_r;
        end
      end
    end
    if ((state_r == ST_MOD) && mod_done && (func_r != FN_GET) && handle_bad) begin
      res_sts_r <= STS_COUNT;
    end
    if (state_r == ST_GWR) begin
      res_hit_r <= found_r;
      res_sts_r <= upd_sts;
      if (found_r) begin
        res_way_r  <= WAY_OUT_W'(hit_way_r);
        res_fill_r <= !hit_vld_r;
      end else if (have_r) begin
        res_way_r  <= WAY_OUT_W'(vic_way_r);
        res_fill_r <= 1'b1;
      end else begin
        res_way_r  <= '0;
        res_fill_r <= 1'b0;
      end
    end
    if (state_r == ST_RMW) begin
      res_sts_r <= upd_sts;
    end
    if (out_load) begin
      out_tdata_r <= {OUT_PAD_W'(0), res_sts_r, res_fill_r, res_hit_r,
                      SET_OUT_W'(set_idx), res_way_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== sv/hbc_checker.sv =====
// Port-level checker for the block cache tag engine, bound to the top level.
`include "hashed_block_cache_lru_refcount_assert.svh"

module hbc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hbc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import hbc_pkg::*;

  logic       in_req;
  logic       out_stall;
  logic [1:0] sts;
  logic       sts_ok;
  logic       noway;
  logic       noway_clean;

  assign in_req      = in_tvalid && in_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign sts         = out_tdata[10:9];
  assign sts_ok      = (sts == STS_OK) || (sts == STS_NOWAY) || (sts == STS_COUNT);
  assign noway       = out_tvalid && (sts == STS_NOWAY);
  assign noway_clean = (out_tdata[2:0] == 3'd0) && !out_tdata[7] && !out_tdata[8];

  // A request occupies the block until its result is registered, so it never takes two in a row.
  `HBC_ASSERT_NXT(a_busy_after_req, in_req, !in_tready, "ready right after a request")

  // A stalled result stays put.
  `HBC_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled result moved")

  // Only the three defined status codes are ever reported.
  `HBC_ASSERT_IMP(a_sts_legal, out_tvalid, sts_ok, "undefined status code")

  // A full set leaves nothing changed and reports way zero with no hit and no fill.
  `HBC_ASSERT_IMP(a_noway_clean, noway, noway_clean, "full-set result carries way, hit or fill")

endmodule

bind hashed_block_cache_lru_refcount hbc_checker u_hbc_checker (.*);

// ===== bench/hashed_block_cache_lru_refcount_tb.sv =====
// Self-checking testbench for the block cache tag and replacement engine.
module hashed_block_cache_lru_refcount_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbc_pkg::*;

  // Geometry of the instance under test; the predictor uses the same values.
  localparam int NSETS    = 13;
  localparam int NWAYS    = 5;
  localparam int NENTRIES = NSETS * NWAYS;

  // Number of random requests, spread evenly over the four idling phases.
  // With the directed plan this makes about a thousand requests in all.
  localparam int RANDOM_REQUESTS = 472;
  // Idle cycles run after the last reply has been taken.
  localparam int DRAIN_CYCLES    = 40;

  // One reply as it appears on out_tdata, from the highest bit down.
  typedef struct packed {
    status_t    status;
    logic       fill;
    logic       hit;
    logic [3:0] set;
    logic [2:0] way;
  } reply_t;

  // A device and block pair that has been asked for, kept so that later gets hit.
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
  } block_tag_t;

  // One line of the directed plan. When has_reply is set, the reply is typed
  // in by hand; otherwise the predictor supplies it.
  typedef struct {
    func_t       fn;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [2:0]  hdl;
    logic [31:0] now;
    int          reps;
    bit          has_reply;
    reply_t      reply;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [1:0]             in_tuser   = FN_GET;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predictor copy of the tag RAM, one entry per set and way.
  logic [7:0]  tag_dev   [NENTRIES];
  logic [31:0] tag_blk   [NENTRIES];
  logic [7:0]  ref_cnt   [NENTRIES];
  logic [31:0] use_stamp [NENTRIES];
  logic        filled    [NENTRIES];

  reply_t     pending_replies[$];
  block_tag_t known_tags[$];
  plan_row_t  plan[$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int mismatches = 0;

  hashed_block_cache_lru_refcount #(
    .NUM_SETS(NSETS),
    .NUM_WAYS(NWAYS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // The result side stalls at random, at the rate set for the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Computes the reply to one request and applies its effect on the tags,
  // counts, stamps and valid bits.
  function automatic reply_t lookup_and_update(func_t fn, logic [7:0] dev, logic [31:0] blk,
                                               logic [2:0] hdl, logic [31:0] now);
    int unsigned set_idx;
    int unsigned base;
    int unsigned e;
    int unsigned pick;
    bit          found;
    bit          have;
    logic [31:0] oldest;
    reply_t      r;
    set_idx  = blk % NSETS;
    base     = set_idx * NWAYS;
    r        = '0;
    r.set    = set_idx[3:0];
    r.status = STS_OK;
    found    = 1'b0;
    have     = 1'b0;
    pick     = 0;
    oldest   = '0;
    if (fn == FN_GET) begin
      // Tags are compared whether or not the way is valid.
      for (int w = 0; w < NWAYS; w++) begin
        if (!found && tag_dev[base + w] == dev && tag_blk[base + w] == blk) begin
          found = 1'b1;
          pick  = w;
        end
      end
      if (found) begin
        e     = base + pick;
        r.way = pick[2:0];
        r.hit = 1'b1;
        if (ref_cnt[e] == CNT_MAX) begin
          r.status = STS_COUNT;
        end else begin
          ref_cnt[e] = ref_cnt[e] + 8'd1;
        end
        use_stamp[e] = now;
        r.fill       = !filled[e];
        filled[e]    = 1'b1;
      end else begin
        // Oldest unreferenced way wins; a strict compare keeps the lowest way on ties.
        for (int w = 0; w < NWAYS; w++) begin
          if (ref_cnt[base + w] == CNT_ZERO && (!have || use_stamp[base + w] < oldest)) begin
            have   = 1'b1;
            oldest = use_stamp[base + w];
            pick   = w;
          end
        end
        if (!have) begin
          r.status = STS_NOWAY;
        end else begin
          e            = base + pick;
          r.way        = pick[2:0];
          tag_dev[e]   = dev;
          tag_blk[e]   = blk;
          use_stamp[e] = now;
          ref_cnt[e]   = CNT_ONE;
          filled[e]    = 1'b1;
          r.fill       = 1'b1;
        end
      end
    end else begin
      r.way = hdl;
      if (hdl >= NWAYS) begin
        r.status = STS_COUNT;
      end else begin
        e = base + hdl;
        if (fn == FN_PIN) begin
          if (ref_cnt[e] == CNT_MAX) begin
            r.status = STS_COUNT;
          end else begin
            ref_cnt[e] = ref_cnt[e] + 8'd1;
          end
        end else if (ref_cnt[e] == CNT_ZERO) begin
          r.status = STS_COUNT;
        end else begin
          ref_cnt[e] = ref_cnt[e] - 8'd1;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Every reply taken by the result side is compared with the oldest one pending.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[10:0];
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with no request outstanding", $realtime);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got.way !== want.way) flag_mismatch("way_out", 32'(got.way), 32'(want.way));
        if (got.set !== want.set) flag_mismatch("set_out", 32'(got.set), 32'(want.set));
        if (got.hit !== want.hit) flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.fill !== want.fill)
          flag_mismatch("needs_fill", 32'(got.fill), 32'(want.fill));
        if (got.status !== want.status)
          flag_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  // Drives one request, holding it until the block takes it. The predictor runs
  // at the accepting edge, so its state follows the order the block sees.
  task automatic send_request(func_t fn, logic [7:0] dev, logic [31:0] blk, logic [2:0] hdl,
                              logic [31:0] now, bit has_reply, reply_t reply);
    reply_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {5'd0, now, hdl, blk, dev};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = lookup_and_update(fn, dev, blk, hdl, now);
    pending_replies.push_back(has_reply ? reply : predicted);
  endtask

  task automatic add_row(func_t fn, logic [7:0] dev, logic [31:0] blk, logic [2:0] hdl,
                         logic [31:0] now, int reps, int has_reply, logic [2:0] way,
                         logic [3:0] set, int hit, int fill, status_t status);
    plan_row_t row;
    row.fn           = fn;
    row.dev          = dev;
    row.blk          = blk;
    row.hdl          = hdl;
    row.now          = now;
    row.reps         = reps;
    row.has_reply    = (has_reply != 0);
    row.reply.way    = way;
    row.reply.set    = set;
    row.reply.hit    = (hit != 0);
    row.reply.fill   = (fill != 0);
    row.reply.status = status;
    plan.push_back(row);
  endtask

  // A generous ceiling on the whole run; a healthy run ends far sooner.
  initial begin
    #10_000_000;
    $display("** hashed_block_cache_lru_refcount: FAILED **");
    $finish;
  end

  initial begin
    block_tag_t  tag;
    func_t       fn;
    logic [2:0]  hdl;
    logic [31:0] now;
    logic [31:0] tick;
    int unsigned set_idx;
    int          busy[NWAYS];
    int          nbusy;
    int          roll;

    for (int e = 0; e < NENTRIES; e++) begin
      tag_dev[e]   = '0;
      tag_blk[e]   = '0;
      ref_cnt[e]   = '0;
      use_stamp[e] = '0;
      filled[e]    = 1'b0;
    end

    // Directed plan. After reset every way holds device 0, block 0, so the
    // first get of that pair hits an untouched way and still asks for a fill.
    add_row(FN_GET,     8'd0,   32'd0,  3'd0, 32'd5,  1, 1, 3'd0, 4'd0,  1, 1, STS_OK);
    add_row(FN_GET,     8'd0,   32'd0,  3'd0, 32'd6,  1, 1, 3'd0, 4'd0,  1, 0, STS_OK);
    add_row(FN_RELEASE, 8'd0,   32'd0,  3'd0, 32'd0,  1, 1, 3'd0, 4'd0,  0, 0, STS_OK);
    add_row(FN_UNPIN,   8'd0,   32'd0,  3'd0, 32'd0,  1, 1, 3'd0, 4'd0,  0, 0, STS_OK);
    // Unpin at count zero underflows and keeps the count.
    add_row(FN_UNPIN,   8'd0,   32'd0,  3'd0, 32'd0,  1, 1, 3'd0, 4'd0,  0, 0, STS_COUNT);
    // Way handles past the set are refused and echoed back.
    add_row(FN_RELEASE, 8'd0,   32'd0,  3'd7, 32'd0,  1, 1, 3'd7, 4'd0,  0, 0, STS_COUNT);
    add_row(FN_PIN,     8'd0,   32'd12, 3'd5, 32'd0,  1, 1, 3'd5, 4'd12, 0, 0, STS_COUNT);
    // Largest device, block and stamp; the block falls in set 8.
    add_row(FN_GET,     8'd255, 32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF,
            1, 1, 3'd0, 4'd8, 0, 1, STS_OK);
    // Fill the rest of set 8 so that every way is referenced.
    add_row(FN_GET,     8'd1,   32'd8,  3'd0, 32'd10, 1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_GET,     8'd1,   32'd21, 3'd0, 32'd11, 1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_GET,     8'd1,   32'd34, 3'd0, 32'd12, 1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_GET,     8'd1,   32'd47, 3'd0, 32'd13, 1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    // A miss in a fully referenced set changes nothing.
    add_row(FN_GET,     8'd1,   32'd60, 3'd0, 32'd14, 1, 1, 3'd0, 4'd8, 0, 0, STS_NOWAY);
    // Freeing way 0, which carries the all-ones stamp: it must still be chosen.
    add_row(FN_RELEASE, 8'd0,   32'd8,  3'd0, 32'd0,  1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_GET,     8'd2,   32'd73, 3'd0, 32'd15, 1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_GET,     8'd255, 32'hFFFF_FFFF, 3'd0, 32'd16, 1, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    // Drive one way of set 3 to the count ceiling, then hit and pin it there.
    add_row(FN_GET,     8'd9,   32'd3,  3'd0, 32'd20, 1,   0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_PIN,     8'd0,   32'd3,  3'd0, 32'd0,  254, 0, 3'd0, 4'd0, 0, 0, STS_OK);
    add_row(FN_GET,     8'd9,   32'd3,  3'd0, 32'd21, 1,   1, 3'd0, 4'd3, 1, 0, STS_COUNT);
    add_row(FN_PIN,     8'd0,   32'd3,  3'd0, 32'd0,  1,   1, 3'd0, 4'd3, 0, 0, STS_COUNT);
    add_row(FN_UNPIN,   8'd0,   32'd3,  3'd0, 32'd0,  255, 0, 3'd0, 4'd0, 0, 0, STS_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        send_request(plan[i].fn, plan[i].dev, plan[i].blk, plan[i].hdl, plan[i].now,
                     plan[i].has_reply, plan[i].reply);
      end
    end

    // Random part in four idling phases: none, sender mostly idle, receiver
    // mostly stalling, and both idling now and then.
    tick = 32'd100;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      repeat (RANDOM_REQUESTS / 4) begin
        // Most requests name a block seen before, so gets hit and the
        // count operations land on sets that are in use.
        if (known_tags.size() != 0 && $urandom_range(0, 99) < 70) begin
          tag = known_tags[$urandom_range(0, known_tags.size() - 1)];
        end else begin
          tag.blk = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 200);
          tag.dev = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                : 8'($urandom_range(0, 255));
        end

        roll = $urandom_range(0, 99);
        if (roll < 40)      fn = FN_GET;
        else if (roll < 65) fn = FN_RELEASE;
        else if (roll < 75) fn = FN_PIN;
        else                fn = FN_UNPIN;

        // Releases and unpins mostly target a referenced way, which keeps the
        // sets from clogging; the rest go anywhere, past the set included.
        set_idx = tag.blk % NSETS;
        nbusy   = 0;
        for (int w = 0; w < NWAYS; w++) begin
          if (ref_cnt[set_idx * NWAYS + w] != CNT_ZERO) begin
            busy[nbusy] = w;
            nbusy++;
          end
        end
        if (fn != FN_GET && fn != FN_PIN && nbusy != 0 && $urandom_range(0, 99) < 75) begin
          hdl = 3'(busy[$urandom_range(0, nbusy - 1)]);
        end else if ($urandom_range(0, 99) < 85) begin
          hdl = 3'($urandom_range(0, NWAYS - 1));
        end else begin
          hdl = 3'($urandom_range(NWAYS, 7));
        end

        // Stamps mostly climb like a timer, with an occasional wild value.
        tick = tick + $urandom_range(1, 4);
        now  = ($urandom_range(0, 99) < 10) ? $urandom() : tick;

        if (fn == FN_GET) begin
          known_tags.push_back(tag);
          if (known_tags.size() > 32) void'(known_tags.pop_front());
        end
        send_request(fn, tag.dev, tag.blk, hdl, now, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("** hashed_block_cache_lru_refcount: PASSED **");
    end else begin
      $display("** hashed_block_cache_lru_refcount: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/hbc_pkg.sv
sv/hbc_ram.sv
sv/hbc_setmod.sv
sv/hbc_cmp.sv
sv/hashed_block_cache_lru_refcount.sv
sv/hbc_checker.sv
bench/hashed_block_cache_lru_refcount_tb.sv
